// ===== sv/wcl_pkg.sv =====
// ---------------------------------------------------------------------------
// wcl_pkg
// shared types, character codes and helpers for the wheel command line parser
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wcl_pkg;

  localparam int WHEELS           = 4;
  localparam int WHEEL_IDX_W      = 3;  // holds 0..WHEELS
  localparam int SPEED_W          = 8;
  localparam int HEADING_W        = 4;
  localparam int BYTE_W           = 8;
  localparam int MAX_LINE_DEFAULT = 64;

  localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;

  typedef enum logic [2:0] {
    CC_DIGIT,
    CC_COMMA,
    CC_CR,
    CC_LF,
    CC_OTHER
  } char_class_t;

  typedef struct packed {
    logic [WHEELS-1:0][SPEED_W-1:0]   speed;
    logic [WHEELS-1:0][HEADING_W-1:0] heading;
  } wcl_result_t;

  function automatic char_class_t classify(input logic [BYTE_W-1:0] c);
    char_class_t cc;
    cc = CC_OTHER;
    if (c == CH_LF) begin
      cc = CC_LF;
    end else if (c == CH_CR) begin
      cc = CC_CR;
    end else if (c == CH_COMMA) begin
      cc = CC_COMMA;
    end else if (c >= CH_ZERO && c <= CH_NINE) begin
      cc = CC_DIGIT;
    end
    return cc;
  endfunction

endpackage

`default_nettype wire

// ===== sv/wcl_parser.sv =====
// ---------------------------------------------------------------------------
// wcl_parser
// field state and per-wheel stores; while take is high, one byte taken per cycle
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wcl_parser #(
  parameter int MAX_LINE = wcl_pkg::MAX_LINE_DEFAULT
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      take,
  input  wire logic [7:0]                byte_in,
  output wcl_pkg::wcl_result_t           line_result
);
  import wcl_pkg::*;

  localparam int LEN_W = $clog2(MAX_LINE);
  localparam logic [LEN_W-1:0] LEN_LAST = LEN_W'(MAX_LINE - 1);

  logic [SPEED_W-1:0]               digit_accumulator, digit_accumulator_next;
  logic                             in_speed_field, in_speed_field_next;
  logic [WHEEL_IDX_W-1:0]           wheel_index, wheel_index_next;
  logic [WHEELS-1:0][SPEED_W-1:0]   speed_store, speed_store_next;
  logic [WHEELS-1:0][HEADING_W-1:0] heading_store, heading_store_next;
  logic                             line_stopped, line_stopped_next;
  logic [LEN_W-1:0]                 line_length, line_length_next;

  char_class_t        cc;
  logic               wheel_open;
  logic [1:0]         wsel;
  logic [3:0]         digit;
  logic [SPEED_W-1:0] acc_times_ten;

  assign cc            = classify(byte_in);
  assign wheel_open    = (wheel_index < WHEEL_IDX_W'(WHEELS));
  assign wsel          = wheel_index[1:0];
  assign digit         = byte_in[3:0];
  assign acc_times_ten = (digit_accumulator << 3) + (digit_accumulator << 1);

  always_comb begin
    digit_accumulator_next = digit_accumulator;
    in_speed_field_next    = in_speed_field;
    wheel_index_next       = wheel_index;
    speed_store_next       = speed_store;
    heading_store_next     = heading_store;
    line_stopped_next      = line_stopped;
    line_length_next       = line_length;
    if (take) begin
      priority if (cc == CC_LF) begin
        digit_accumulator_next = '0;
        in_speed_field_next    = 1'b1;
        wheel_index_next       = '0;
        speed_store_next       = '0;
        heading_store_next     = '0;
        line_stopped_next      = 1'b0;
        line_length_next       = '0;
      end else if (!line_stopped && line_length != LEN_LAST) begin
        line_length_next = line_length + LEN_W'(1);
        unique case (cc)
          CC_CR: begin
            if (!in_speed_field && wheel_open) begin
              heading_store_next[wsel] = digit_accumulator[HEADING_W-1:0];
              wheel_index_next         = wheel_index + WHEEL_IDX_W'(1);
            end
            line_stopped_next = 1'b1;
          end
          CC_COMMA: begin
            if (wheel_open) begin
              if (in_speed_field) begin
                speed_store_next[wsel] = digit_accumulator;
              end else begin
                heading_store_next[wsel] = digit_accumulator[HEADING_W-1:0];
                wheel_index_next         = wheel_index + WHEEL_IDX_W'(1);
              end
            end
            digit_accumulator_next = '0;
            in_speed_field_next    = !in_speed_field;
          end
          CC_DIGIT: begin
            if (in_speed_field) begin
              digit_accumulator_next = acc_times_ten + SPEED_W'(digit);
            end else begin
              digit_accumulator_next = SPEED_W'(digit);
            end
          end
          default: begin
          end
        endcase
      end else begin
      end
    end
  end

  // result as seen by a line-feed: an open direction field is closed here
  always_comb begin
    line_result.speed   = speed_store;
    line_result.heading = heading_store;
    if (!line_stopped && !in_speed_field && wheel_open) begin
      line_result.heading[wsel] = digit_accumulator[HEADING_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_accumulator <= '0;
      in_speed_field    <= 1'b1;
      wheel_index       <= '0;
      speed_store       <= '0;
      heading_store     <= '0;
      line_stopped      <= 1'b0;
      line_length       <= '0;
    end else begin
      digit_accumulator <= digit_accumulator_next;
      in_speed_field    <= in_speed_field_next;
      wheel_index       <= wheel_index_next;
      speed_store       <= speed_store_next;
      heading_store     <= heading_store_next;
      line_stopped      <= line_stopped_next;
      line_length       <= line_length_next;
    end
  end

  a_wheel_bound: assert property (@(posedge clk) disable iff (rst)
    wheel_index <= WHEEL_IDX_W'(WHEELS))
    else $error("wheel index past last wheel");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    line_length <= LEN_LAST)
    else $error("line length past limit");

  a_lf_clears: assert property (@(posedge clk) disable iff (rst)
    (take && cc == CC_LF) |=> (wheel_index == '0 && in_speed_field &&
                               !line_stopped && line_length == '0 &&
                               speed_store == '0 && heading_store == '0))
    else $error("line-feed did not restart the line");

endmodule

`default_nettype wire

// ===== sv/wcl_out_stage.sv =====
// ---------------------------------------------------------------------------
// wcl_out_stage
// result register holding one line result until the sink takes it
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wcl_out_stage (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 load,
  input  wire wcl_pkg::wcl_result_t load_data,
  input  wire logic                 out_stall,
  output logic                      out_valid,
  output logic                      slot_free,
  output wcl_pkg::wcl_result_t      held
);
  import wcl_pkg::*;

  logic out_valid_next;

  assign slot_free      = !out_valid || !out_stall;
  assign out_valid_next = load || (out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= load_data;
    end
  end

endmodule

`default_nettype wire

// ===== sv/wheel_command_line_parser_core.sv =====
// ---------------------------------------------------------------------------
// wheel_command_line_parser_core
// parses "speed,dir" x4 command lines, one ASCII byte per beat, and emits
// the four speeds and directions on each line-feed
// ---------------------------------------------------------------------------
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------
//  input   | sink      | in_valid / in_stall    | rx_byte
//  output  | source    | out_valid / out_stall  | speed_0..3, heading_0..3
//
// - one input beat per cycle unless in_stall; a byte waits in the input register
//   and is parsed there by a short combinational step into the field state
// - a line-feed produces one output beat, in the cycle after it is parsed
// - in_stall rises only when a line-feed is waiting and the result register
//   still holds an untaken beat under out_stall; other bytes never stall
// - synchronous reset clears the parse state, the stores and both valid flags
`timescale 1ns / 1ps
`default_nettype none

module wheel_command_line_parser_core #(
  parameter int MAX_LINE = wcl_pkg::MAX_LINE_DEFAULT
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] rx_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      speed_0,
  output logic [7:0]      speed_1,
  output logic [7:0]      speed_2,
  output logic [7:0]      speed_3,
  output logic [3:0]      heading_0,
  output logic [3:0]      heading_1,
  output logic [3:0]      heading_2,
  output logic [3:0]      heading_3
);
  import wcl_pkg::*;

  // input register
  logic              byte_valid;
  logic [BYTE_W-1:0] byte_reg;

  logic        is_lf;
  logic        slot_free;
  logic        advance;
  logic        in_take;
  wcl_result_t line_result;
  wcl_result_t held;

  assign is_lf   = (classify(byte_reg) == CC_LF);
  // a line-feed may only move on when the result register can take it
  assign advance = byte_valid && (!is_lf || slot_free);
  assign in_stall = byte_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (in_take) begin
      byte_valid <= 1'b1;
    end else if (advance) begin
      byte_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      byte_reg <= rx_byte;
    end
  end

  // field parsing and per-wheel stores
  wcl_parser #(
    .MAX_LINE (MAX_LINE)
  ) u_parser (
    .clk         (clk),
    .rst         (rst),
    .take        (advance),
    .byte_in     (byte_reg),
    .line_result (line_result)
  );

  // result register, loaded on a parsed line-feed
  wcl_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && is_lf),
    .load_data (line_result),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .slot_free (slot_free),
    .held      (held)
  );

  assign speed_0   = held.speed[0];
  assign speed_1   = held.speed[1];
  assign speed_2   = held.speed[2];
  assign speed_3   = held.speed[3];
  assign heading_0 = held.heading[0];
  assign heading_1 = held.heading[1];
  assign heading_2 = held.heading[2];
  assign heading_3 = held.heading[3];

  a_lf_emits: assert property (@(posedge clk) disable iff (rst)
    (advance && is_lf) |=> out_valid)
    else $error("parsed line-feed produced no result beat");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(held)))
    else $error("stalled result beat changed or dropped");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (byte_valid && is_lf && out_valid && out_stall))
    else $error("input stalled without a blocked line-feed");

endmodule

`default_nettype wire
